[design/apm_pkg.sv]
// ----------------------------------------------------------------------------
// apm_pkg: shared types and constants for the peak meter
// Log2 table, conversion constants, register indexes, queue entry type.
// ----------------------------------------------------------------------------
`default_nettype none
package apm_pkg;

  localparam int unsigned GainW = 18;
  localparam int unsigned DbW   = 16;
  localparam int unsigned LvlW  = 24;
  localparam int unsigned MsW   = 16;
  localparam int unsigned RateW = 16;
  localparam int unsigned ChW   = 4;

  // 20*log10(2) in Q16
  localparam logic [18:0] DbScale = 19'd394566;

  typedef enum logic [1:0] {
    REG_MIN_DB    = 2'd0,
    REG_SLOW_RATE = 2'd1,
    REG_FAST_RATE = 2'd2
  } reg_idx_e;

  // round(65536*log2(1+i/16))
  function automatic logic [16:0] log2_tab(input logic [4:0] i);
    logic [16:0] v;
    case (i)
      5'd0:  v = 17'd0;
      5'd1:  v = 17'd5732;
      5'd2:  v = 17'd11136;
      5'd3:  v = 17'd16248;
      5'd4:  v = 17'd21098;
      5'd5:  v = 17'd25711;
      5'd6:  v = 17'd30109;
      5'd7:  v = 17'd34312;
      5'd8:  v = 17'd38336;
      5'd9:  v = 17'd42196;
      5'd10: v = 17'd45904;
      5'd11: v = 17'd49472;
      5'd12: v = 17'd52911;
      5'd13: v = 17'd56229;
      5'd14: v = 17'd59434;
      5'd15: v = 17'd62534;
      5'd16: v = 17'd65536;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

  // Classified word passed from the front end to the back end
  typedef struct packed {
    logic [ChW-1:0]        channel;
    logic                  in_range;
    logic signed [DbW-1:0] reading;
    logic [MsW-1:0]        elapsed_ms;
    logic                  clr_falloff;
  } item_t;

endpackage
`default_nettype wire

[design/audio_peak_meter_ballistics.sv]
// ----------------------------------------------------------------------------
// audio_peak_meter_ballistics: multi-channel peak meter with decay and holds
// Throughput: one word per cycle while the output is not back-pressured; the level update is a same-cycle RMW.
// Conversion pipeline is 3 stages, decoupled from the update by a 4-deep queue.
// Reset: asynchronous, active low; all levels return to -70 dB, registers
// to their defaults. No clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none
module audio_peak_meter_ballistics #(
  parameter int unsigned CHANNELS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // channel[3:0], gain[21:4], elapsed_ms[37:22]
  input  wire logic [39:0] s_tdata,
  // clr_falloff
  input  wire logic        s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // out_channel[3:0], max_db[19:4], slow[35:20], fast[51:36],
  // falloff[67:52], peak[83:68]
  output logic [87:0]      m_tdata,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  logic signed [15:0] min_db_q;
  logic [15:0]        slow_rate_q, fast_rate_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_db_q    <= -16'sd17920;
      slow_rate_q <= 16'd1311;
      fast_rate_q <= 16'd13107;
    end else if (cfg_valid_i) begin
      case (apm_pkg::reg_idx_e'(cfg_index_i))
        apm_pkg::REG_MIN_DB:    min_db_q    <= cfg_data_i;
        apm_pkg::REG_SLOW_RATE: slow_rate_q <= cfg_data_i;
        apm_pkg::REG_FAST_RATE: fast_rate_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // front accepts while the queue can hold every word already in flight
  logic           f_valid, q_valid, take;
  logic [2:0]     q_cnt;
  logic [1:0]     f_cnt;
  apm_pkg::item_t f_item, q_item;
  logic           en;

  // pipeline only advances; queued plus in-flight words plus the new one
  // must fit in four slots, counting the word the back end takes this cycle
  assign en       = 1'b1;
  assign s_tready = (4'(q_cnt) + 4'(f_cnt)) <= (4'd3 + 4'(take));

  apm_front #(.CHANNELS(CHANNELS)) u_front (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i        (s_tvalid && s_tready),
    .channel_i      (s_tdata[3:0]),
    .gain_i         (s_tdata[21:4]),
    .elapsed_ms_i   (s_tdata[37:22]),
    .clr_falloff_i  (s_tuser),
    .min_db_i       (min_db_q),
    .valid_o        (f_valid),
    .inflight_o     (f_cnt),
    .item_o         (f_item)
  );

  apm_queue u_queue (
    .clk_i, .rst_ni,
    .push_i (f_valid),
    .data_i (f_item),
    .pop_i  (take),
    .valid_o(q_valid),
    .data_o (q_item),
    .count_o(q_cnt)
  );

  apm_back #(.CHANNELS(CHANNELS)) u_back (
    .clk_i, .rst_ni,
    .valid_i    (q_valid),
    .item_i     (q_item),
    .take_o     (take),
    .min_db_i   (min_db_q),
    .slow_rate_i(slow_rate_q),
    .fast_rate_i(fast_rate_q),
    .m_tvalid,
    .m_tready,
    .m_tdata
  );

endmodule
`default_nettype wire

[design/apm_front.sv]
// ----------------------------------------------------------------------------
// apm_front: gain to dB conversion
// Three register stages: log2, scale multiply, round and floor.
// ----------------------------------------------------------------------------
`default_nettype none
module apm_front #(
  parameter int unsigned CHANNELS = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           en_i,
  input  wire logic                           valid_i,
  input  wire logic [apm_pkg::ChW-1:0]        channel_i,
  input  wire logic [apm_pkg::GainW-1:0]      gain_i,
  input  wire logic [apm_pkg::MsW-1:0]        elapsed_ms_i,
  input  wire logic                           clr_falloff_i,
  input  wire logic signed [apm_pkg::DbW-1:0] min_db_i,
  output logic                                valid_o,
  output logic [1:0]                          inflight_o,
  output apm_pkg::item_t                      item_o
);

  // stage 1: log2 in Q16, signed
  logic [4:0]         lead;
  logic [16:0]        frac;
  logic [16:0]        t0, t1, fpart;
  logic [30:0]        interp;
  logic signed [21:0] l2;
  logic [34:0]        norm;
  logic [apm_pkg::GainW-1:0] gain;

  assign gain = gain_i;

  always_comb begin
    lead = '0;
    for (int i = 0; i < 18; i++) begin
      if (gain[i]) lead = 5'(i);
    end
    norm   = {17'd0, gain} << (5'd17 - lead);
    frac   = norm[16:0];
    t0     = apm_pkg::log2_tab({1'b0, frac[16:13]});
    t1     = apm_pkg::log2_tab({1'b0, frac[16:13]} + 5'd1);
    interp = 31'(t1 - t0) * 31'(frac[12:0]);
    fpart  = t0 + 17'(interp >> 13);
    l2     = (22'(signed'({1'b0, lead})) - 22'sd16) * 22'sd65536
             + 22'(signed'({1'b0, fpart}));
  end

  logic               v1_q, v2_q, v3_q;
  logic               z1_q, z2_q;
  logic               n1_q, n2_q;
  logic [20:0]        mag1_q;
  logic [39:0]        prod2_q;
  apm_pkg::item_t     it1_q, it2_q, it3_q;

  logic [20:0] mag;
  assign mag = l2[21] ? 21'(-l2) : 21'(l2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  logic [15:0] q;
  logic signed [apm_pkg::DbW-1:0] db;
  always_comb begin
    q  = 16'((prod2_q + 40'd8388608) >> 24);
    db = n2_q ? -signed'(q) : signed'(q);
    if (z2_q || db < min_db_i) db = min_db_i;
  end

  apm_pkg::item_t it1_d, it3_d;
  always_comb begin
    it1_d.channel     = channel_i;
    it1_d.in_range    = (9'(channel_i) < 9'(CHANNELS));
    it1_d.reading     = '0;
    it1_d.elapsed_ms  = elapsed_ms_i;
    it1_d.clr_falloff = clr_falloff_i;
    it3_d             = it2_q;
    it3_d.reading     = db;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag1_q  <= mag;
      n1_q    <= l2[21];
      z1_q    <= (gain_i == '0);
      it1_q   <= it1_d;
      prod2_q <= 40'(mag1_q) * 40'(apm_pkg::DbScale);
      n2_q    <= n1_q;
      z2_q    <= z1_q;
      it2_q   <= it1_q;
      it3_q   <= it3_d;
    end
  end

  assign valid_o    = v3_q;
  assign inflight_o = {1'b0, v1_q} + {1'b0, v2_q} + {1'b0, v3_q};
  assign item_o     = it3_q;

endmodule
`default_nettype wire

[design/apm_queue.sv]
// ----------------------------------------------------------------------------
// apm_queue: small FIFO between conversion and level update
// Depth four, absorbs the front pipeline's in-flight words.
// ----------------------------------------------------------------------------
`default_nettype none
module apm_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  apm_pkg::item_t      data_i,
  input  wire logic           pop_i,
  output logic                valid_o,
  output apm_pkg::item_t      data_o,
  output logic [2:0]          count_o
);

  apm_pkg::item_t mem_q [4];
  logic [1:0] wp_q, rp_q;
  logic [2:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 2'd1;
      if (pop_i)  rp_q <= rp_q + 2'd1;
      cnt_q <= cnt_q + 3'(push_i) - 3'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rp_q];
  assign count_o = cnt_q;

endmodule
`default_nettype wire

[design/apm_back.sv]
// ----------------------------------------------------------------------------
// apm_back: per-channel level update
// Read-modify-write of the channel state within the same cycle, result in output reg.
// ----------------------------------------------------------------------------
`default_nettype none
module apm_back #(
  parameter int unsigned CHANNELS = 16
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             valid_i,
  input  apm_pkg::item_t                        item_i,
  output logic                                  take_o,
  input  wire logic signed [apm_pkg::DbW-1:0]   min_db_i,
  input  wire logic [apm_pkg::RateW-1:0]        slow_rate_i,
  input  wire logic [apm_pkg::RateW-1:0]        fast_rate_i,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic [87:0]                           m_tdata
);

  localparam int unsigned Depth = (CHANNELS < 16) ? CHANNELS : 16;
  localparam int unsigned IdxW  = (Depth > 1) ? $clog2(Depth) : 1;

  // reset value of min_db in each state format
  localparam logic signed [apm_pkg::DbW-1:0]  RstDb  = -16'sd17920;
  localparam logic signed [apm_pkg::LvlW-1:0] RstLvl = -24'sd4587520;

  logic signed [apm_pkg::LvlW-1:0] slow_q [Depth];
  logic signed [apm_pkg::LvlW-1:0] fast_q [Depth];
  logic signed [apm_pkg::DbW-1:0]  fall_q [Depth];
  logic signed [apm_pkg::DbW-1:0]  peak_q [Depth];

  function automatic logic signed [23:0] decay(
    input logic signed [23:0] lvl,
    input logic signed [15:0] rd,
    input logic [15:0]        ms,
    input logic [15:0]        rate,
    input logic signed [15:0] floor_db
  );
    logic signed [33:0] up, n, fl;
    up = 34'(rd) <<< 8;
    fl = 34'(floor_db) <<< 8;
    n  = 34'(lvl) - signed'({2'b0, 32'(ms) * 32'(rate)});
    if (up > 34'(lvl)) return 24'(up);
    if (n < fl) return 24'(fl);
    return 24'(n);
  endfunction

  logic [IdxW-1:0] idx;
  logic signed [23:0] s_n, f_n;
  logic signed [15:0] fo_n, pk_n, rd;
  logic [87:0] res;

  assign take_o = valid_i && (!m_tvalid || m_tready);
  assign idx    = IdxW'(item_i.channel);
  assign rd     = item_i.reading;

  always_comb begin
    s_n  = decay(slow_q[idx], rd, item_i.elapsed_ms, slow_rate_i, min_db_i);
    f_n  = decay(fast_q[idx], rd, item_i.elapsed_ms, fast_rate_i, min_db_i);
    fo_n = (item_i.clr_falloff || rd > fall_q[idx]) ? rd : fall_q[idx];
    pk_n = (rd > peak_q[idx]) ? rd : peak_q[idx];
    if (item_i.in_range)
      res = {4'd0, pk_n, fo_n, f_n[23:8], s_n[23:8], rd, 4'(item_i.channel)};
    else
      res = {4'd0, min_db_i, min_db_i, min_db_i, min_db_i, rd, 4'(item_i.channel)};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tvalid <= 1'b0;
      for (int i = 0; i < Depth; i++) begin
        slow_q[i] <= RstLvl;
        fast_q[i] <= RstLvl;
        fall_q[i] <= RstDb;
        peak_q[i] <= RstDb;
      end
    end else begin
      if (take_o) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      if (take_o && item_i.in_range) begin
        slow_q[idx] <= s_n;
        fast_q[idx] <= f_n;
        fall_q[idx] <= fo_n;
        peak_q[idx] <= pk_n;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) m_tdata <= res;
  end

endmodule
`default_nettype wire

[design/apm_checker.sv]
// ----------------------------------------------------------------------------
// apm_checker: port-level checks for the peak meter
// Output handshake stability, peak ordering and no unprompted results.
// ----------------------------------------------------------------------------
`default_nettype none
module apm_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [87:0] m_tdata,
  input wire logic        s_tvalid,
  input wire logic        s_tready
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result dropped while stalled");

  a_peak_ge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid |-> $signed(m_tdata[83:68]) >= $signed(m_tdata[67:52]) ||
                 $signed(m_tdata[83:68]) >= $signed(m_tdata[19:4]))
    else $error("peak below reading");

  // an idle output only wakes up for a word accepted at the input and passed through the front stages and queue
  a_no_out_unprompted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 5))
    else $error("spurious result");

endmodule

bind audio_peak_meter_ballistics apm_checker u_apm_checker (.*);
`default_nettype wire

[test/audio_peak_meter_ballistics_test.sv]
// ----------------------------------------------------------------------------
// audio_peak_meter_ballistics_test: self-checking bench for the peak meter
// Drives meter update words with random gaps, predicts each result word from
// a behavioural copy of the per-channel levels and compares field by field.
// ----------------------------------------------------------------------------
`default_nettype none
module audio_peak_meter_ballistics_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumChannels = 16;
  localparam int LimitCycles = 400000;

  typedef struct packed {
    logic [3:0]  channel;
    logic [17:0] gain;
    logic [15:0] elapsed_ms;
    logic        clr_falloff;
  } update_t;

  // last member sits in the lowest bits, matching the result word layout
  typedef struct packed {
    logic signed [15:0] peak_db;
    logic signed [15:0] falloff_db;
    logic signed [15:0] fast_db;
    logic signed [15:0] slow_db;
    logic signed [15:0] max_db;
    logic [3:0]         channel;
  } levels_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [87:0] m_tdata;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  audio_peak_meter_ballistics dut (.*);

  always #1 clk_i = ~clk_i;

  // Predictor state: register copies and per-channel levels
  logic signed [15:0] floor_db;
  logic [15:0]        slow_rate, fast_rate;
  logic signed [23:0] slow_lvl [NumChannels];
  logic signed [23:0] fast_lvl [NumChannels];
  logic signed [15:0] falloff_lvl [NumChannels];
  logic signed [15:0] peak_lvl [NumChannels];

  update_t pending_words[$];
  levels_t expected_levels[$];
  int      errors = 0;
  longint  cycles = 0;
  bit      stall_on = 1'b1;

  const int unsigned Lut [17] = '{0, 5732, 11136, 16248, 21098, 25711, 30109, 34312,
    38336, 42196, 45904, 49472, 52911, 56229, 59434, 62534, 65536};

  function automatic logic signed [15:0] gain_db(logic [17:0] g);
    int          p;
    longint      l2, mag, q, db;
    int unsigned nrm, fr, ix, r;
    if (g == 0) return floor_db;
    p = 17;
    while (p > 0 && g[p] == 1'b0) p--;
    nrm = 32'(g) << (17 - p);
    fr  = nrm & 32'h1FFFF;
    ix  = fr >> 13;
    r   = fr & 32'h1FFF;
    l2  = longint'(p - 16) * 65536 + Lut[ix] + (((Lut[ix+1] - Lut[ix]) * r) >> 13);
    mag = (l2 < 0) ? -l2 : l2;
    q   = (mag * 394566 + 8388608) >>> 24;
    db  = (l2 < 0) ? -q : q;
    if (db < floor_db) db = floor_db;
    return 16'(db);
  endfunction

  function automatic logic signed [23:0] fall_level(logic signed [23:0] lvl,
      logic signed [15:0] rd, logic [15:0] ms, logic [15:0] rate);
    longint up, n;
    up = longint'(rd) * 256;
    if (up > longint'(lvl)) return 24'(up);
    n = longint'(lvl) - longint'(ms) * longint'(rate);
    if (n < longint'(floor_db) * 256) n = longint'(floor_db) * 256;
    return 24'(n);
  endfunction

  // Work out the result word for one accepted update and advance the state
  function automatic levels_t meter_update(update_t u);
    levels_t e;
    logic signed [15:0] rd;
    rd = gain_db(u.gain);
    e.channel = u.channel;
    e.max_db  = rd;
    slow_lvl[u.channel] = fall_level(slow_lvl[u.channel], rd, u.elapsed_ms, slow_rate);
    fast_lvl[u.channel] = fall_level(fast_lvl[u.channel], rd, u.elapsed_ms, fast_rate);
    if (u.clr_falloff || rd > falloff_lvl[u.channel]) falloff_lvl[u.channel] = rd;
    if (rd > peak_lvl[u.channel]) peak_lvl[u.channel] = rd;
    // Q8.16 to Q8.8 with an arithmetic shift: floor toward minus infinity
    e.slow_db    = 16'(slow_lvl[u.channel] >>> 8);
    e.fast_db    = 16'(fast_lvl[u.channel] >>> 8);
    e.falloff_db = falloff_lvl[u.channel];
    e.peak_db    = peak_lvl[u.channel];
    return e;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // Short gaps mostly, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Driver: one word on the bus at a time, random gaps between words
  int drv_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_tvalid && s_tready) begin
        expected_levels.push_back(meter_update(pending_words.pop_front()));
      end
      if (!(s_tvalid && !s_tready)) begin
        if (drv_gap > 0 || pending_words.size() == 0) begin
          s_tvalid <= 1'b0;
          if (drv_gap > 0) drv_gap <= drv_gap - 1;
        end else begin
          // an accepted word has already been popped, so the head is next
          s_tvalid <= 1'b1;
          s_tdata  <= {2'b00, pending_words[0].elapsed_ms,
                       pending_words[0].gain,
                       pending_words[0].channel};
          s_tuser  <= pending_words[0].clr_falloff;
          drv_gap  <= stall_on ? gap_len() : 0;
        end
      end
    end
  end

  // Monitor: random backpressure, check each result word against the oldest
  int mon_gap = 0;
  always @(posedge clk_i) begin
    levels_t got, want;
    if (rst_ni) begin
      if (m_tvalid && m_tready) begin
        got = levels_t'(m_tdata[83:0]);
        if (expected_levels.size() == 0) begin
          report_mismatch("unexpected word, channel", got.channel, -1);
        end else begin
          want = expected_levels.pop_front();
          if (got.channel !== want.channel)
            report_mismatch("channel", got.channel, want.channel);
          if (got.max_db !== want.max_db) report_mismatch("max_db", got.max_db, want.max_db);
          if (got.slow_db !== want.slow_db)
            report_mismatch("slow_level", got.slow_db, want.slow_db);
          if (got.fast_db !== want.fast_db)
            report_mismatch("fast_level", got.fast_db, want.fast_db);
          if (got.falloff_db !== want.falloff_db)
            report_mismatch("falloff", got.falloff_db, want.falloff_db);
          if (got.peak_db !== want.peak_db)
            report_mismatch("peak", got.peak_db, want.peak_db);
        end
      end
      if (mon_gap > 0) begin
        m_tready <= 1'b0;
        mon_gap  <= mon_gap - 1;
      end else begin
        m_tready <= 1'b1;
        mon_gap  <= stall_on ? gap_len() : 0;
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LimitCycles) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Register write on the config channel; predictor copy updated alongside
  task automatic write_reg(apm_pkg::reg_idx_e idx, logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      apm_pkg::REG_MIN_DB:    floor_db  = val;
      apm_pkg::REG_SLOW_RATE: slow_rate = val;
      apm_pkg::REG_FAST_RATE: fast_rate = val;
      default: ;
    endcase
  endtask

  // Let everything queued drain and every expected result arrive, then a margin
  task automatic drain();
    while (pending_words.size() != 0 || s_tvalid || expected_levels.size() != 0)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  function automatic update_t rand_word();
    update_t u;
    int r;
    u.channel = 4'($urandom_range(0, 15));
    r = $urandom_range(0, 9);
    // Mix of silence, full scale, tiny and arbitrary gains
    case (r)
      0: u.gain = '0;
      1: u.gain = 18'h3FFFF;
      2: u.gain = 18'($urandom_range(1, 64));
      default: u.gain = 18'($urandom);
    endcase
    r = $urandom_range(0, 9);
    u.elapsed_ms = (r < 6) ? 16'($urandom_range(0, 100)) :
                   (r < 9) ? 16'($urandom_range(0, 3000)) : 16'($urandom);
    u.clr_falloff = ($urandom_range(0, 7) == 0);
    return u;
  endfunction

  task automatic push(logic [3:0] ch, logic [17:0] g, logic [15:0] ms, logic rf);
    update_t u;
    u.channel = ch; u.gain = g; u.elapsed_ms = ms; u.clr_falloff = rf;
    pending_words.push_back(u);
  endtask

  initial begin
    floor_db  = -16'sd17920;
    slow_rate = 16'd1311;
    fast_rate = 16'd13107;
    for (int c = 0; c < NumChannels; c++) begin
      slow_lvl[c] = 24'(-17920 * 256);
      fast_lvl[c] = 24'(-17920 * 256);
      falloff_lvl[c] = -16'sd17920;
      peak_lvl[c] = -16'sd17920;
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: zero gain, unity, full scale, single lsb, powers of two,
    // decay to the floor, falloff forced down, long elapsed times
    push(4'd0, 18'd0, 16'd0, 1'b0);
    push(4'd0, 18'h3FFFF, 16'd0, 1'b0);
    push(4'd0, 18'd65536, 16'd10, 1'b0);
    push(4'd0, 18'd1, 16'd1, 1'b1);
    push(4'd0, 18'd0, 16'hFFFF, 1'b0);
    push(4'd15, 18'd32768, 16'd0, 1'b0);
    push(4'd15, 18'd100, 16'd500, 1'b1);
    push(4'd15, 18'd131072, 16'd1, 1'b0);
    push(4'd15, 18'h15555, 16'h8000, 1'b0);
    push(4'd7, 18'd2, 16'd0, 1'b1);
    push(4'd7, 18'd4096, 16'd2, 1'b0);
    push(4'd7, 18'h2AAAA, 16'd3, 1'b1);
    drain();

    // Extreme settings: floor at 0 dB and at the bottom, rates at both ends
    write_reg(apm_pkg::REG_MIN_DB, 16'h0000);
    write_reg(apm_pkg::REG_SLOW_RATE, 16'hFFFF);
    write_reg(apm_pkg::REG_FAST_RATE, 16'h0000);
    push(4'd3, 18'd1, 16'd5, 1'b0);
    push(4'd3, 18'h3FFFF, 16'd5, 1'b0);
    push(4'd3, 18'd30000, 16'hFFFF, 1'b1);
    push(4'd0, 18'd0, 16'd1, 1'b0);
    drain();
    write_reg(apm_pkg::REG_MIN_DB, 16'h8000);
    write_reg(apm_pkg::REG_SLOW_RATE, 16'h0000);
    write_reg(apm_pkg::REG_FAST_RATE, 16'hFFFF);
    push(4'd9, 18'd0, 16'hFFFF, 1'b1);
    push(4'd9, 18'd1, 16'hFFFF, 1'b0);
    push(4'd9, 18'd0, 16'hFFFF, 1'b0);
    drain();

    // Random phases with different register settings; one phase without gaps
    for (int ph = 0; ph < 8; ph++) begin
      stall_on = (ph != 3);
      if (ph == 0) begin
        write_reg(apm_pkg::REG_MIN_DB, -16'sd17920);
        write_reg(apm_pkg::REG_SLOW_RATE, 16'd1311);
        write_reg(apm_pkg::REG_FAST_RATE, 16'd13107);
      end else begin
        write_reg(apm_pkg::REG_MIN_DB, 16'(-$urandom_range(0, 32768)));
        write_reg(apm_pkg::REG_SLOW_RATE, 16'($urandom));
        write_reg(apm_pkg::REG_FAST_RATE, 16'($urandom));
      end
      for (int i = 0; i < 100; i++) pending_words.push_back(rand_word());
      drain();
    end

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
